FILE: sv/fisr_pkg.sv
package fisr_pkg;

   localparam logic [31:0] MAGIC        = 32'h5F37_59DF;
   localparam logic [31:0] ONE_HALF     = 32'h3F00_0000;
   localparam logic [31:0] THREE_HALVES = 32'h3FC0_0000;
   localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
   localparam logic [30:0] INF_BODY     = 31'h7F80_0000;

   function automatic logic [5:0] clz48(input logic [47:0] x);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && x[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] clz27(input logic [26:0] x);
      logic [4:0] n;
      logic       found;
      n = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && x[i]) begin
            n = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

FILE: sv/fast_inverse_square_root_unit.sv
// channel   direction  ports              word
// req       in         req_tvalid/tready  req_tdata[31:0]  operand_bits
// rsp       out        rsp_tvalid/tready  rsp_tdata[31:0]  result_bits
//
// ten register stages: four multiplies of two stages each and one subtract
// of two stages; one word accepted per cycle unless a stall backs up to req
// reset clears only the stage valid bits
// a stall holds a stage only while it is full and the next one cannot take
// its word, so bubbles close up behind a stalled result
module fast_inverse_square_root_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operand_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // result_bits
);

   logic [10:1] valid_ff;
   logic [11:1] en;
   logic [31:0] g_ff [1:8];
   logic [31:0] half_ff, hg_ff, t_ff, corr_ff, res_ff;
   logic [31:0] half_in, hg_in, t_in, corr_in, res_in;
   logic [31:0] guess;

   always_comb begin
      en[11] = rsp_tready;
      for (int k = 10; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k + 1];
      end
   end

   assign req_tready = en[1];
   assign guess = fisr_pkg::MAGIC - {req_tdata[31], req_tdata[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 10; k >= 2; k--) begin
            if (en[k]) valid_ff[k] <= valid_ff[k - 1];
         end
         if (en[1]) valid_ff[1] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) g_ff[1] <= guess;
      for (int k = 2; k <= 8; k++) begin
         if (en[k]) g_ff[k] <= g_ff[k - 1];
      end
      if (en[2]) half_ff <= half_in;
      if (en[4]) hg_ff <= hg_in;
      if (en[6]) t_ff <= t_in;
      if (en[8]) corr_ff <= corr_in;
      if (en[10]) res_ff <= res_in;
   end

   fisr_fmul u_half (
      .clock   (clock),
      .enable  (en[1]),
      .a       (req_tdata),
      .b       (fisr_pkg::ONE_HALF),
      .product (half_in)
   );

   fisr_fmul u_hg (
      .clock   (clock),
      .enable  (en[3]),
      .a       (half_ff),
      .b       (g_ff[2]),
      .product (hg_in)
   );

   fisr_fmul u_t (
      .clock   (clock),
      .enable  (en[5]),
      .a       (hg_ff),
      .b       (g_ff[4]),
      .product (t_in)
   );

   fisr_fadd u_corr (
      .clock  (clock),
      .enable (en[7]),
      .a      (fisr_pkg::THREE_HALVES),
      .b      ({~t_ff[31], t_ff[30:0]}),
      .sum    (corr_in)
   );

   fisr_fmul u_res (
      .clock   (clock),
      .enable  (en[9]),
      .a       (g_ff[8]),
      .b       (corr_ff),
      .product (res_in)
   );

   assign rsp_tvalid = valid_ff[10];
   assign rsp_tdata  = res_ff;

endmodule

FILE: sv/fisr_fmul.sv
module fisr_fmul (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] product
);

   logic [47:0]        prod_ff, prod_in;
   logic signed [10:0] esum_ff, esum_in;
   logic               sign_ff, sign_in;
   logic               nan_ff, nan_in;
   logic               inf_ff, inf_in;
   logic               zero_ff, zero_in;

   // unpack and multiply significands
   always_comb begin
      logic [7:0]  xa, xb;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      prod_in = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
      esum_in = $signed({3'b000, xa}) + $signed({3'b000, xb}) - 11'sd126;
      sign_in = a[31] ^ b[31];
      nan_in  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      inf_in  = a_inf | b_inf;
      zero_in = a_zero | b_zero;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         esum_ff <= esum_in;
         sign_ff <= sign_in;
         nan_ff  <= nan_in;
         inf_ff  <= inf_in;
         zero_ff <= zero_in;
      end
   end

   // normalize and round to nearest even
   always_comb begin
      logic [5:0]         lz;
      logic [47:0]        pn;
      logic [47:0]        sh_val;
      logic signed [10:0] be;
      logic signed [10:0] sh;
      logic [5:0]         shc;
      logic [23:0]        mant;
      logic [7:0]         field;
      logic               grd, stk, rnd;
      logic [30:0]        body;
      lz = fisr_pkg::clz48(prod_ff);
      pn = prod_ff << lz;
      be = esum_ff - $signed({5'b00000, lz});
      sh = 11'sd1 - be;
      shc = (sh > 11'sd48) ? 6'd48 : sh[5:0];
      sh_val = pn >> shc;
      if (be >= 11'sd1) begin
         mant  = pn[47:24];
         grd   = pn[23];
         stk   = |pn[22:0];
         field = be[7:0];
      end else begin
         mant   = sh_val[47:24];
         grd    = sh_val[23];
         stk    = (|sh_val[22:0]) | (|(pn & ~(48'hFFFF_FFFF_FFFF << shc)));
         field  = 8'd0;
      end
      rnd  = grd & (stk | mant[0]);
      body = {field, mant[22:0]} + {30'd0, rnd};
      if (nan_ff) begin
         product = fisr_pkg::CANON_NAN;
      end else if (inf_ff || (be >= 11'sd255)) begin
         product = {sign_ff, fisr_pkg::INF_BODY};
      end else if (zero_ff) begin
         product = {sign_ff, 31'd0};
      end else begin
         product = {sign_ff, body};
      end
   end

endmodule

FILE: sv/fisr_fadd.sv
module fisr_fadd (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] sum
);

   logic [27:0] sum_ff, sum_in;
   logic [7:0]  exp_ff, exp_in;
   logic        sign_ff, sign_in;
   logic        zsign_ff, zsign_in;
   logic        nan_ff, nan_in;
   logic        inf_ff, inf_in;
   logic        isign_ff, isign_in;

   // order by magnitude, align, add or subtract
   always_comb begin
      logic [31:0] big, sml;
      logic [7:0]  xb, xs, d;
      logic [4:0]  dc;
      logic [26:0] mb, ms, sm;
      logic        a_nan, b_nan, a_inf, b_inf;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      xb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      xs = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d  = xb - xs;
      dc = (d > 8'd27) ? 5'd27 : d[4:0];
      mb = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      ms = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
      sm = ms >> dc;
      sm[0] = sm[0] | (|(ms & ~(27'h7FF_FFFF << dc)));
      if (a[31] != b[31]) begin
         sum_in = {1'b0, mb} - {1'b0, sm};
      end else begin
         sum_in = {1'b0, mb} + {1'b0, sm};
      end
      exp_in   = xb;
      sign_in  = big[31];
      zsign_in = a[31] & b[31];
      nan_in   = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      inf_in   = a_inf | b_inf;
      isign_in = a_inf ? a[31] : b[31];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff   <= sum_in;
         exp_ff   <= exp_in;
         sign_ff  <= sign_in;
         zsign_ff <= zsign_in;
         nan_ff   <= nan_in;
         inf_ff   <= inf_in;
         isign_ff <= isign_in;
      end
   end

   // normalize and round to nearest even
   always_comb begin
      logic [4:0]  lz;
      logic [26:0] m;
      logic [8:0]  field;
      logic        rnd;
      logic [30:0] body;
      lz = fisr_pkg::clz27(sum_ff[26:0]);
      if (sum_ff[27]) begin
         m     = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         field = {1'b0, exp_ff} + 9'd1;
      end else if ({3'b000, lz} <= (exp_ff - 8'd1)) begin
         m     = sum_ff[26:0] << lz;
         field = {1'b0, exp_ff} - {4'd0, lz};
      end else begin
         m     = sum_ff[26:0] << (exp_ff - 8'd1);
         field = 9'd0;
      end
      rnd  = m[2] & ((|m[1:0]) | m[3]);
      body = {field[7:0], m[25:3]} + {30'd0, rnd};
      if (nan_ff) begin
         sum = fisr_pkg::CANON_NAN;
      end else if (inf_ff) begin
         sum = {isign_ff, fisr_pkg::INF_BODY};
      end else if (sum_ff == 28'd0) begin
         sum = {zsign_ff, 31'd0};
      end else if (field >= 9'd255) begin
         sum = {sign_ff, fisr_pkg::INF_BODY};
      end else begin
         sum = {sign_ff, body};
      end
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int LATENCY     = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 550;

   class rsqrt_scoreboard;
      logic [31:0] pending[$];
      int          errors;

      function bit is_nan(logic [31:0] b);
         return b[30:23] == 8'hFF && b[22:0] != 0;
      endfunction

      function bit is_inf(logic [31:0] b);
         return b[30:0] == fisr_pkg::INF_BODY;
      endfunction

      function bit is_zero(logic [31:0] b);
         return b[30:0] == 31'b0;
      endfunction

      // value = m * 2^e
      function void unpack(logic [31:0] b, output logic [127:0] m, output int e);
         if (b[30:23] == 8'h00) begin
            m = 128'(b[22:0]);
            e = -149;
         end else begin
            m = 128'({1'b1, b[22:0]});
            e = int'(b[30:23]) - 150;
         end
      endfunction

      // round m * 2^e (m may carry a sticky lsb) to binary32, nearest even
      function logic [31:0] round_f32(bit s, logic [127:0] m, int e);
         int p, sh, q;
         logic [127:0] mt, rem, half;
         if (m == 0) return {s, 31'b0};
         p = 127;
         while (!m[p]) p--;
         if (p + e + 127 >= 1) sh = p - 23;
         else sh = -149 - e;
         q = e + sh;
         if (sh <= 0) begin
            mt = m << (-sh);
         end else if (sh > 127) begin
            mt = 0;
         end else begin
            mt = m >> sh;
            rem = m - (mt << sh);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && mt[0])) mt++;
         end
         if (mt[24]) begin
            mt = mt >> 1;
            q++;
         end
         if (mt[23]) begin
            if (q + 150 >= 255) return {s, fisr_pkg::INF_BODY};
            return {s, 8'(q + 150), mt[22:0]};
         end
         return {s, 8'h00, mt[22:0]};
      endfunction

      function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
         logic [127:0] ma, mb;
         int ea, eb;
         bit s;
         s = a[31] ^ b[31];
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return fisr_pkg::CANON_NAN;
            return {s, fisr_pkg::INF_BODY};
         end
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         return round_f32(s, ma * mb, ea + eb);
      endfunction

      function logic [127:0] align(logic [127:0] m, int e, int ec);
         int d;
         if (e >= ec) return m << (e - ec);
         d = ec - e;
         if (d >= 100) return 128'(m != 0);
         return (m >> d) | 128'((m & ((128'd1 << d) - 1)) != 0);
      endfunction

      function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
         logic [127:0] ma, mb, xa, xb, sum;
         int ea, eb, ec;
         bit s;
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fisr_pkg::CANON_NAN;
         if (is_inf(a)) return a;
         if (is_inf(b)) return b;
         if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         ec = ((ea > eb) ? ea : eb) - 40;
         xa = align(ma, ea, ec);
         xb = align(mb, eb, ec);
         if (a[31] == b[31]) begin
            sum = xa + xb;
            s = a[31];
         end else if (xa >= xb) begin
            sum = xa - xb;
            s = a[31];
         end else begin
            sum = xb - xa;
            s = b[31];
         end
         if (sum == 0) return 32'h0;
         return round_f32(s, sum, ec);
      endfunction

      function logic [31:0] rsqrt_estimate(logic [31:0] op);
         logic [31:0] guess, half, hg, t, corr, r;
         guess = fisr_pkg::MAGIC - {op[31], op[31:1]};
         half = fmul(op, fisr_pkg::ONE_HALF);
         hg = fmul(half, guess);
         t = fmul(hg, guess);
         corr = fadd(fisr_pkg::THREE_HALVES, {~t[31], t[30:0]});
         r = fmul(guess, corr);
         return is_nan(r) ? fisr_pkg::CANON_NAN : r;
      endfunction

      function void note_operand(logic [31:0] op);
         pending.push_back(rsqrt_estimate(op));
      endfunction

      function void check_result(logic [31:0] result_bits);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $error("unexpected word result_bits=%h", result_bits);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (result_bits !== want) begin
            $error("result_bits mismatch: expected %h actual %h", want, result_bits);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // operand_bits
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result_bits

   rsqrt_scoreboard sb = new();
   bit  no_idle;
   int  cycles = 0;
   int  rsp_hold;

   fast_inverse_square_root_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_word(logic [31:0] op);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0, 1: return $urandom();
         2:    return {1'b0, 8'($urandom_range(96, 159)), 23'($urandom())};
         3:    return {1'($urandom()), 8'h00, 23'($urandom())};
         4:    return {1'($urandom()), 8'($urandom_range(0, 3) == 0 ? 8'hFF : 8'hFE),
                       23'($urandom())};
         default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
      endcase
   endfunction

   // receiver stall
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_operand(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] directed[$];
      no_idle = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 32'h0;
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4080_0000,
                   32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                   32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
                   32'h7F7F_FFFF, 32'hBF80_0000, 32'h3F00_0000, 32'h8000_0001,
                   32'h5F37_59DF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3E80_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_word(directed[i]);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 64 == 0) no_idle <= ($urandom_range(0, 3) == 0);
         send_word(random_operand());
      end
      req_tvalid <= 1'b0;
      no_idle <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
